// File: src/crf_pkg.sv
package crf_pkg;

  // Screen dimension limit (columns and rows are clamped to this)
  localparam int MaxDimDefault = 4096;

  localparam int PixelBytes = 4;

  // Result status codes
  localparam logic [1:0] ST_ROW    = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  // Command kinds handed from front to back
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_REJECT = 2'd1;
  localparam logic [1:0] CMD_EMPTY  = 2'd2;
  localparam logic [1:0] CMD_STEP   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_BASE = 2'd0;
  localparam logic [1:0] REG_COLUMNS    = 2'd1;
  localparam logic [1:0] REG_ROWS       = 2'd2;
  localparam logic [1:0] REG_PITCH      = 2'd3;

  typedef struct packed {
    logic [31:0] frame_base;
    logic [12:0] screen_columns;
    logic [12:0] screen_rows;
    logic [15:0] row_pitch_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] y_offset;   // origin_y * pitch
    logic [12:0] x_pixel;    // clipped-in origin_x
    logic [12:0] words;
    logic [12:0] rows;
    logic [31:0] color;
  } cmd_t;

endpackage

// File: src/crf_front.sv
module crf_front import crf_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  cfg_t        cfg,
  input  logic        mode,
  input  logic [15:0] origin_x,
  input  logic [15:0] origin_y,
  input  logic [15:0] rect_width,
  input  logic [15:0] rect_height,
  input  logic [31:0] color,
  output cmd_t        cmd
);

  localparam logic [14:0] MaxDimL = 15'(MAX_DIM);

  logic [12:0] cols;
  logic [12:0] rows;
  logic        disabled;
  logic        off_screen;
  logic [12:0] span_x;
  logic [12:0] span_y;
  logic [12:0] w_clip;
  logic [12:0] h_clip;

  always_comb begin
    // Clamp the screen to the supported size
    cols = ({2'b00, cfg.screen_columns} > MaxDimL) ? MaxDimL[12:0] : cfg.screen_columns;
    rows = ({2'b00, cfg.screen_rows} > MaxDimL) ? MaxDimL[12:0] : cfg.screen_rows;

    disabled   = (cfg.frame_base == '0) || (cols == '0) || (rows == '0) ||
                 (cfg.row_pitch_bytes == '0);
    off_screen = (origin_x >= {3'b000, cols}) || (origin_y >= {3'b000, rows});

    span_x = cols - origin_x[12:0];
    span_y = rows - origin_y[12:0];
    w_clip = (rect_width  > {3'b000, span_x}) ? span_x : rect_width[12:0];
    h_clip = (rect_height > {3'b000, span_y}) ? span_y : rect_height[12:0];

    cmd.y_offset = 32'({16'h0000, origin_y} * {16'h0000, cfg.row_pitch_bytes});
    cmd.x_pixel  = origin_x[12:0];
    cmd.words    = w_clip;
    cmd.rows     = h_clip;
    cmd.color    = color;

    if (mode) begin
      cmd.kind = CMD_STEP;
    end else if (disabled || off_screen) begin
      cmd.kind = CMD_REJECT;
    end else if ((w_clip == '0) || (h_clip == '0)) begin
      cmd.kind = CMD_EMPTY;
    end else begin
      cmd.kind = CMD_LOAD;
    end
  end

endmodule

// File: src/crf_queue.sv
module crf_queue import crf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/crf_back.sv
module crf_back import crf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        row_valid,
  output logic [31:0] row_address,
  output logic [12:0] row_words,
  output logic [31:0] fill_value,
  output logic        last_row,
  output logic [1:0]  status
);

  logic        active_r,    active_nxt;
  logic [31:0] next_addr_r, next_addr_nxt;
  logic [12:0] rows_left_r, rows_left_nxt;
  logic [12:0] words_r,     words_nxt;
  logic [31:0] color_r,     color_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        row_valid_r, row_valid_nxt;
  logic [31:0] address_r,   address_nxt;
  logic [12:0] row_words_r, row_words_nxt;
  logic [31:0] fill_r,      fill_nxt;
  logic        last_r,      last_nxt;
  logic [1:0]  status_r,    status_nxt;

  logic        emit;
  logic [31:0] emit_addr;
  logic [12:0] emit_rows;
  logic [12:0] emit_words;
  logic [31:0] emit_color;
  logic        emit_last;

  assign cmd_pop = cmd_valid && (!out_valid_r || out_ready);

  always_comb begin
    active_nxt    = active_r;
    next_addr_nxt = next_addr_r;
    rows_left_nxt = rows_left_r;
    words_nxt     = words_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && !out_ready;
    row_valid_nxt = row_valid_r;
    address_nxt   = address_r;
    row_words_nxt = row_words_r;
    fill_nxt      = fill_r;
    last_nxt      = last_r;
    status_nxt    = status_r;

    // Pick where the row comes from: a fresh rectangle or the pending one
    if (cmd.kind == CMD_LOAD) begin
      emit_addr  = cfg.frame_base + cmd.y_offset + {17'h0_0000, cmd.x_pixel, 2'b00};
      emit_rows  = cmd.rows;
      emit_words = cmd.words;
      emit_color = cmd.color;
    end else begin
      emit_addr  = next_addr_r;
      emit_rows  = rows_left_r;
      emit_words = words_r;
      emit_color = color_r;
    end
    emit_last = (emit_rows <= 13'd1);

    case (cmd.kind)
      CMD_LOAD: emit = 1'b1;
      CMD_STEP: emit = active_r;
      default:  emit = 1'b0;
    endcase

    if (cmd_pop) begin
      out_valid_nxt = 1'b1;
      if (emit) begin
        row_valid_nxt = 1'b1;
        address_nxt   = emit_addr;
        row_words_nxt = emit_words;
        fill_nxt      = emit_color;
        last_nxt      = emit_last;
        status_nxt    = ST_ROW;
        next_addr_nxt = emit_addr + {16'h0000, cfg.row_pitch_bytes};
        rows_left_nxt = (emit_rows == '0) ? '0 : emit_rows - 13'd1;
        words_nxt     = emit_words;
        color_nxt     = emit_color;
        active_nxt    = !emit_last;
      end else begin
        row_valid_nxt = 1'b0;
        address_nxt   = '0;
        row_words_nxt = '0;
        fill_nxt      = '0;
        last_nxt      = 1'b0;
        case (cmd.kind)
          CMD_REJECT: status_nxt = ST_REJECT;
          CMD_EMPTY:  status_nxt = ST_EMPTY;
          default:    status_nxt = ST_IDLE;
        endcase
        if (cmd.kind != CMD_STEP) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      next_addr_r <= '0;
      rows_left_r <= '0;
      words_r     <= '0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      next_addr_r <= next_addr_nxt;
      rows_left_r <= rows_left_nxt;
      words_r     <= words_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_valid_r <= row_valid_nxt;
    address_r   <= address_nxt;
    row_words_r <= row_words_nxt;
    fill_r      <= fill_nxt;
    last_r      <= last_nxt;
    status_r    <= status_nxt;
  end

  assign out_valid   = out_valid_r;
  assign row_valid   = row_valid_r;
  assign row_address = address_r;
  assign row_words   = row_words_r;
  assign fill_value  = fill_r;
  assign last_row    = last_r;
  assign status      = status_r;

endmodule

// File: src/clipped_rectangle_fill_rows.sv
// Clipped rectangle fill for a 32-bit-per-pixel linear framebuffer.
// Program the four registers over cfg_* (frame base, columns, rows, pitch)
// while the block is idle. Each item on the in_ channel yields exactly one
// result item on the out_ channel. A load item (in_tuser = 0) checks the
// rectangle against the screen, clips it and, unless it is rejected or
// empty, issues its first row burst; each step item (in_tuser = 1) issues
// the next row of the pending rectangle, if one is pending. A result
// carries the row's byte address, word count and fill value, tlast marks
// the final row, and tuser carries row_valid and status. An accepted item
// passes the combinational classify stage into a two-entry command queue,
// then the row sequencer that owns the pending-rectangle state and the
// output register. Throughput is one item per cycle while out_tready is
// high, set by the pitch add and row decrement in the sequencer.
// Reset clears the queue, the pending rectangle, the output valid flag and
// all configuration registers. When the receiver holds out_tready low the
// output register holds its item, the queue fills, and in_tready drops
// once both queue entries are taken.
module clipped_rectangle_fill_rows import crf_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  // origin_x[15:0], origin_y[31:16], rect_width[47:32], rect_height[63:48],
  // color[95:64]
  input  logic [95:0] in_tdata,
  // mode[0]
  input  logic [0:0]  in_tuser,
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  // row_address[31:0], row_words[44:32], fill_value[76:45], zero pad[79:77]
  output logic [79:0] out_tdata,
  // last_row
  output logic        out_tlast,
  // row_valid[0], status[2:1]
  output logic [2:0]  out_tuser
);

  cfg_t cfg_r;
  cfg_t front_cmd_cfg;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;

  logic        row_valid;
  logic [31:0] row_address;
  logic [12:0] row_words;
  logic [31:0] fill_value;
  logic        last_row;
  logic [1:0]  status;

  // Configuration registers: taken on any cycle with the write enable high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_BASE: cfg_r.frame_base      <= cfg_wdata;
        REG_COLUMNS:    cfg_r.screen_columns  <= cfg_wdata[12:0];
        REG_ROWS:       cfg_r.screen_rows     <= cfg_wdata[12:0];
        REG_PITCH:      cfg_r.row_pitch_bytes <= cfg_wdata[15:0];
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

  assign front_cmd_cfg = cfg_r;

  // Classify every item as it arrives; only the queue's fill level gates input
  crf_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .cfg         (front_cmd_cfg),
    .mode        (in_tuser[0]),
    .origin_x    (in_tdata[15:0]),
    .origin_y    (in_tdata[31:16]),
    .rect_width  (in_tdata[47:32]),
    .rect_height (in_tdata[63:48]),
    .color       (in_tdata[95:64]),
    .cmd         (front_cmd)
  );

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  crf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  // Row sequencer: holds the pending rectangle and drives the output register
  crf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cmd_valid   (q_valid),
    .cmd         (head_cmd),
    .cmd_pop     (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .row_valid   (row_valid),
    .row_address (row_address),
    .row_words   (row_words),
    .fill_value  (fill_value),
    .last_row    (last_row),
    .status      (status)
  );

  assign out_tdata = {3'b000, fill_value, row_words, row_address};
  assign out_tlast = last_row;
  assign out_tuser = {status, row_valid};

endmodule

// File: src/crf_checker.sv
module crf_checker import crf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // No burst means zero payload and no last flag
  a_no_burst_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata == '0) && !out_tlast &&
    (out_tuser[2:1] != ST_ROW))
    else $error("non-burst result carries payload");

  // A burst always reports row issued and a nonzero word count
  a_burst_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tuser[2:1] == ST_ROW) &&
    (out_tdata[44:32] != '0))
    else $error("burst with bad status or word count");

  // Output is empty right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind clipped_rectangle_fill_rows crf_checker u_crf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
